@@ src/hw2d_pkg.sv @@
// shared types and constants for the multilevel 2d haar transform block
package hw2d_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int CFG_DW = 7;
  localparam int CFG_IW = 2;
  localparam int LVL_W  = 3;
  localparam int SMP_W  = 16;
  localparam int POS_W  = 6;
  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;
  localparam int IN_DW  = 32;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_LEVELS = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    T_IDLE,
    T_LEVEL,
    T_LINE,
    T_A_RDA,
    T_A_RDB,
    T_A_WR,
    T_B_RD,
    T_B_WR
  } tr_state_t;

  // halve a 33-bit sum, rounding toward zero
  function automatic logic [COEF_W-1:0] half_tz(input logic signed [COEF_W:0] s);
    logic signed [COEF_W:0] t;
    t = s + {{COEF_W{1'b0}}, s[COEF_W]};
    return t[COEF_W:1];
  endfunction

endpackage

@@ src/hw2d_store.sv @@
// single-port patch memory with registered read data
module hw2d_store #(
  parameter int DEPTH = hw2d_pkg::MAX_WIDTH_DEF * hw2d_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [hw2d_pkg::COEF_W-1:0] wdata,
  output logic [hw2d_pkg::COEF_W-1:0] rdata
);

  logic [hw2d_pkg::COEF_W-1:0] mem [DEPTH];
  logic [hw2d_pkg::COEF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/hw2d_pair.sv @@
// haar butterfly: average and half difference of one pair
module hw2d_pair (
  input  logic [hw2d_pkg::COEF_W-1:0] a,
  input  logic [hw2d_pkg::COEF_W-1:0] b,
  output logic [hw2d_pkg::COEF_W-1:0] lo,
  output logic [hw2d_pkg::COEF_W-1:0] hi
);

  logic signed [hw2d_pkg::COEF_W:0] sum;
  logic signed [hw2d_pkg::COEF_W:0] dif;

  always_comb begin
    sum = $signed({a[hw2d_pkg::COEF_W-1], a}) + $signed({b[hw2d_pkg::COEF_W-1], b});
    dif = $signed({a[hw2d_pkg::COEF_W-1], a}) - $signed({b[hw2d_pkg::COEF_W-1], b});
    lo  = hw2d_pkg::half_tz(sum);
    hi  = hw2d_pkg::half_tz(dif);
  end

endmodule

@@ src/hw2d_seq.sv @@
// in-place transform sequencer: levels, row and column passes, pair steps
module hw2d_seq #(
  parameter int MAX_WIDTH  = hw2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hw2d_pkg::MAX_HEIGHT_DEF,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int DW         = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               wd,
  input  logic [DW-1:0]               ht,
  input  logic [hw2d_pkg::LVL_W-1:0]  lvl,
  input  logic [hw2d_pkg::COEF_W-1:0] rdata,
  output logic                        st_we,
  output logic [AW-1:0]               st_addr,
  output logic [hw2d_pkg::COEF_W-1:0] st_wdata,
  output logic                        busy,
  output logic                        finish
);

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int HD   = (MAXD / 2 > 1) ? MAXD / 2 : 2;
  localparam int HIW  = $clog2(HD);

  hw2d_pkg::tr_state_t state_r, state_nxt;

  logic [hw2d_pkg::LVL_W-1:0]  lv_r, lv_nxt;
  logic                        col_r, col_nxt;
  logic [DW-1:0]               w_r, w_nxt, h_r, h_nxt, k_r, k_nxt, i_r, i_nxt;
  logic [AW-1:0]               base_r, base_nxt, rp_r, rp_nxt, wp_r, wp_nxt;
  logic [hw2d_pkg::COEF_W-1:0] a_r, a_nxt;

  logic [DW-1:0]               len, half, nlines, rest;
  logic [AW-1:0]               step, stride;
  logic [hw2d_pkg::COEF_W-1:0] lo, hi, hb_q;
  logic                        hb_we;

  logic [hw2d_pkg::COEF_W-1:0] hbuf [HD];

  hw2d_pair u_pair (
    .a (a_r),
    .b (rdata),
    .lo(lo),
    .hi(hi)
  );

  always_comb begin
    len    = col_r ? h_r : w_r;
    half   = len >> 1;
    rest   = len - half;
    nlines = col_r ? w_r : h_r;
    step   = col_r ? AW'(wd) : AW'(1);
    stride = col_r ? AW'(1) : AW'(wd);
  end

  always_ff @(posedge clk) begin
    if (hb_we) begin
      hbuf[i_r[HIW-1:0]] <= hi;
    end
    hb_q <= hbuf[i_r[HIW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hw2d_pkg::T_IDLE:  if (start) state_nxt = hw2d_pkg::T_LEVEL;
      hw2d_pkg::T_LEVEL: state_nxt = (lv_r == lvl) ? hw2d_pkg::T_IDLE : hw2d_pkg::T_LINE;
      hw2d_pkg::T_LINE: begin
        if (k_r == nlines) state_nxt = col_r ? hw2d_pkg::T_LEVEL : hw2d_pkg::T_LINE;
        else state_nxt = hw2d_pkg::T_A_RDA;
      end
      hw2d_pkg::T_A_RDA: state_nxt = (i_r == half) ? hw2d_pkg::T_B_RD : hw2d_pkg::T_A_RDB;
      hw2d_pkg::T_A_RDB: state_nxt = hw2d_pkg::T_A_WR;
      hw2d_pkg::T_A_WR:  state_nxt = hw2d_pkg::T_A_RDA;
      hw2d_pkg::T_B_RD:  state_nxt = (i_r == rest) ? hw2d_pkg::T_LINE : hw2d_pkg::T_B_WR;
      hw2d_pkg::T_B_WR:  state_nxt = hw2d_pkg::T_B_RD;
      default:           state_nxt = hw2d_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    lv_nxt   = lv_r;
    col_nxt  = col_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    k_nxt    = k_r;
    i_nxt    = i_r;
    base_nxt = base_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    a_nxt    = a_r;
    st_we    = 1'b0;
    st_addr  = rp_r;
    st_wdata = lo;
    hb_we    = 1'b0;
    unique case (state_r)
      hw2d_pkg::T_IDLE: begin
        if (start) begin
          lv_nxt = '0;
          w_nxt  = wd;
          h_nxt  = ht;
        end
      end
      hw2d_pkg::T_LEVEL: begin
        col_nxt  = 1'b0;
        k_nxt    = '0;
        base_nxt = '0;
      end
      hw2d_pkg::T_LINE: begin
        if (k_r == nlines) begin
          if (col_r) begin
            w_nxt  = w_r >> 1;
            h_nxt  = h_r >> 1;
            lv_nxt = lv_r + 1'b1;
          end else begin
            col_nxt  = 1'b1;
            k_nxt    = '0;
            base_nxt = '0;
          end
        end else begin
          rp_nxt = base_r;
          wp_nxt = base_r;
          i_nxt  = '0;
        end
      end
      hw2d_pkg::T_A_RDA: begin
        st_addr = rp_r;
        if (i_r == half) i_nxt = '0;
      end
      hw2d_pkg::T_A_RDB: begin
        st_addr = rp_r + step;
        rp_nxt  = rp_r + step + step;
        a_nxt   = rdata;
      end
      hw2d_pkg::T_A_WR: begin
        st_we    = 1'b1;
        st_addr  = wp_r;
        st_wdata = lo;
        hb_we    = 1'b1;
        wp_nxt   = wp_r + step;
        i_nxt    = i_r + 1'b1;
      end
      hw2d_pkg::T_B_RD: begin
        if (i_r == rest) begin
          base_nxt = base_r + stride;
          k_nxt    = k_r + 1'b1;
        end
      end
      hw2d_pkg::T_B_WR: begin
        st_we    = 1'b1;
        st_addr  = wp_r;
        st_wdata = (i_r < half) ? hb_q : '0;
        wp_nxt   = wp_r + step;
        i_nxt    = i_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign busy   = (state_r != hw2d_pkg::T_IDLE);
  assign finish = (state_r == hw2d_pkg::T_LEVEL) && (lv_r == lvl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hw2d_pkg::T_IDLE;
      lv_r    <= '0;
      col_r   <= 1'b0;
      w_r     <= '0;
      h_r     <= '0;
      k_r     <= '0;
      i_r     <= '0;
      base_r  <= '0;
      rp_r    <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lv_r    <= lv_nxt;
      col_r   <= col_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      base_r  <= base_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
    end
    a_r <= a_nxt;
  end

endmodule

@@ src/haar_wavelet_2d_multilevel_core.sv @@
// top level: patch loading, coefficient reads, transform control
//
//  channel  | ports                        | carries
//  ---------+------------------------------+-----------------------------------
//  input    | in_tvalid/in_tready          | load or read request
//  output   | out_tvalid/out_tready        | coefficient and ready flag
//  config   | cfg_we/cfg_index/cfg_wdata   | patch_width, patch_height, levels
//
// a load is written on acceptance; a read passes the store and output registers
// and waits for out_tready. the last load starts the transform: per level and
// line, read-read-write per pair and read-write per copied high-half element,
// plus line control steps, all on the one store port; no request is taken meanwhile
// reset clears load position and done flag, presets config; the store needs no clearing
module haar_wavelet_2d_multilevel_core #(
  parameter int MAX_WIDTH  = hw2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hw2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hw2d_pkg::IN_DW-1:0]  in_tdata,   // sample[15:0], read_row[21:16], read_col[27:22]
  input  logic                        in_tuser,   // action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hw2d_pkg::COEF_W-1:0] out_tdata,  // coefficient[31:0]
  output logic                        out_tuser,  // ready_res
  input  logic                        cfg_we,
  input  logic [hw2d_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hw2d_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

  logic [hw2d_pkg::CFG_DW-1:0] pw_r, ph_r;
  logic [hw2d_pkg::LVL_W-1:0]  lvl_r;
  logic [AW:0]                 lp_r, lp_nxt;
  logic                        done_r, done_nxt;
  logic                        rd_pend_r, hit_r, rdy_r;
  logic                        out_valid_r;
  logic [hw2d_pkg::COEF_W-1:0] out_data_r;
  logic                        out_user_r;

  logic [DW-1:0]               wd, ht;
  logic [31:0]                 total, lp_base, rd_lin;
  logic                        acc, ld_acc, rd_acc, start, hit, cfg_hit;
  logic [hw2d_pkg::POS_W-1:0]  rrow, rcol;
  logic [hw2d_pkg::SMP_W-1:0]  smp;

  logic                        seq_we, seq_busy, seq_finish;
  logic [AW-1:0]               seq_addr;
  logic [hw2d_pkg::COEF_W-1:0] seq_wdata;
  logic                        st_we;
  logic [AW-1:0]               st_addr;
  logic [hw2d_pkg::COEF_W-1:0] st_wdata, st_rdata;

  always_comb begin
    wd = (pw_r == '0) ? DW'(1) :
         ((32'(pw_r) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(pw_r));
    ht = (ph_r == '0) ? DW'(1) :
         ((32'(ph_r) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(ph_r));
    total = 32'(wd) * 32'(ht);
    smp   = in_tdata[15:0];
    rrow  = in_tdata[21:16];
    rcol  = in_tdata[27:22];
    rd_lin = 32'(rrow) * 32'(wd) + 32'(rcol);
  end

  assign in_tready = !seq_busy && !rd_pend_r && !out_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign ld_acc    = acc && (in_tuser == hw2d_pkg::ACT_LOAD);
  assign rd_acc    = acc && (in_tuser == hw2d_pkg::ACT_READ);
  assign cfg_hit   = cfg_we && (cfg_index == hw2d_pkg::REG_WIDTH ||
                                cfg_index == hw2d_pkg::REG_HEIGHT ||
                                cfg_index == hw2d_pkg::REG_LEVELS);
  assign hit       = done_r && (32'(rrow) < 32'(ht)) && (32'(rcol) < 32'(wd));

  always_comb begin
    lp_base = (done_r || 32'(lp_r) >= total) ? 32'd0 : 32'(lp_r);
    start   = ld_acc && (lp_base + 32'd1 >= total);
    lp_nxt  = lp_r;
    done_nxt = done_r;
    if (ld_acc) begin
      lp_nxt   = (AW + 1)'(lp_base + 32'd1);
      done_nxt = 1'b0;
    end
    if (seq_finish) done_nxt = 1'b1;
    if (cfg_hit) begin
      lp_nxt   = '0;
      done_nxt = 1'b0;
    end
  end

  always_comb begin
    if (seq_busy) begin
      st_we    = seq_we;
      st_addr  = seq_addr;
      st_wdata = seq_wdata;
    end else begin
      st_we    = ld_acc;
      st_addr  = ld_acc ? lp_base[AW-1:0] : rd_lin[AW-1:0];
      st_wdata = {smp, {hw2d_pkg::FRAC_W{1'b0}}};
    end
  end

  hw2d_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .addr (st_addr),
    .wdata(st_wdata),
    .rdata(st_rdata)
  );

  hw2d_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW),
    .DW        (DW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .wd      (wd),
    .ht      (ht),
    .lvl     (lvl_r),
    .rdata   (st_rdata),
    .st_we   (seq_we),
    .st_addr (seq_addr),
    .st_wdata(seq_wdata),
    .busy    (seq_busy),
    .finish  (seq_finish)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r        <= hw2d_pkg::CFG_DW'(64);
      ph_r        <= hw2d_pkg::CFG_DW'(64);
      lvl_r       <= hw2d_pkg::LVL_W'(1);
      lp_r        <= '0;
      done_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hw2d_pkg::REG_WIDTH:  pw_r  <= cfg_wdata;
          hw2d_pkg::REG_HEIGHT: ph_r  <= cfg_wdata;
          hw2d_pkg::REG_LEVELS: lvl_r <= cfg_wdata[hw2d_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      lp_r      <= lp_nxt;
      done_r    <= done_nxt;
      rd_pend_r <= rd_acc;
      if (rd_pend_r) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    if (rd_acc) begin
      hit_r <= hit;
      rdy_r <= done_r;
    end
    if (rd_pend_r) begin
      out_data_r <= hit_r ? st_rdata : '0;
      out_user_r <= rdy_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_no_coef_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("coefficient nonzero while transform not done");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy |-> !in_tready)
    else $error("request accepted during transform");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> seq_busy && !done_r)
    else $error("transform did not start after last sample");

endmodule
